>>> rtl/btb_pkg.sv
`default_nettype none
package btb_pkg;

  localparam int MAX_ENTRIES = 32;
  localparam int MAX_HISTORY = 8;
  localparam int CFG_W = 5;

  localparam logic [2:0] CFG_ENTRIES_LOG2 = 3'd0;
  localparam logic [2:0] CFG_HISTORY_BITS = 3'd1;
  localparam logic [2:0] CFG_TAG_BITS = 3'd2;
  localparam logic [2:0] CFG_INITIAL_STATE = 3'd3;
  localparam logic [2:0] CFG_USE_GLOBAL_HISTORY = 3'd4;
  localparam logic [2:0] CFG_USE_GLOBAL_TABLE = 3'd5;
  localparam logic [2:0] CFG_SHARE_MODE = 3'd6;

  localparam logic OP_PREDICT = 1'b0;
  localparam logic OP_RESOLVE = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [31:0] pc;
    logic [31:0] resolved_target;
    logic        resolved_taken;
    logic [31:0] used_prediction;
  } in_item_t;

  typedef struct packed {
    logic        predict_taken;
    logic [31:0] next_fetch_address;
    logic [31:0] branch_count;
    logic [31:0] flush_count;
  } out_item_t;

  typedef struct packed {
    logic [2:0] entries_log2;
    logic [3:0] history_bits;
    logic [4:0] tag_bits;
    logic [1:0] initial_state;
    logic       use_global_history;
    logic       use_global_table;
    logic [1:0] share_mode;
  } cfg_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_OUT
  } state_t;

endpackage
`default_nettype wire

>>> rtl/btb_counter_mem.sv
`default_nettype none
module btb_counter_mem #(
  parameter int ENTRIES = btb_pkg::MAX_ENTRIES,
  parameter int HIST = btb_pkg::MAX_HISTORY,
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  localparam int RW = 1 << HIST
) (
  input  wire logic            clk,
  input  wire logic [IW-1:0]   rd_row,
  input  wire logic [HIST-1:0] rd_col,
  output logic      [1:0]      rd_data,
  input  wire logic            wr_row_en,
  input  wire logic [IW-1:0]   wr_row,
  input  wire logic [1:0]      wr_fill,
  input  wire logic            wr_cell_en,
  input  wire logic [HIST-1:0] wr_col,
  input  wire logic [1:0]      wr_data
);

  logic [2*RW-1:0] mem [ENTRIES];
  logic [2*RW-1:0] row_val;

  // filled row with one counter replaced
  always_comb begin
    row_val = {RW{wr_fill}};
    row_val[2*wr_col +: 2] = wr_data;
  end

  // row-wide memory: fill writes a whole row, cell write a single counter
  always_ff @(posedge clk) begin
    if (wr_row_en) begin
      mem[wr_row] <= wr_cell_en ? row_val : {RW{wr_fill}};
    end else if (wr_cell_en) begin
      mem[wr_row][2*wr_col +: 2] <= wr_data;
    end
    rd_data <= mem[rd_row][2*rd_col +: 2];
  end

endmodule
`default_nettype wire

>>> rtl/btb_two_level_branch_predictor.sv
`default_nettype none
// an accepted item is registered with its memory reads, then executed into the result registers
// a new item is accepted only while idle; accept, execute and output run in turn
//   since each item reads then writes back the counter and entry memories
// reset: clears control, counts, valid bits and histories, then sweeps the counter
//   memories with initial_state over max(MAX_ENTRIES, 2**MAX_HISTORY) addresses, 256 by
//   default; an initial_state write while idle or clearing restarts the same sweep
module btb_two_level_branch_predictor #(
  parameter int MAX_ENTRIES = btb_pkg::MAX_ENTRIES,
  parameter int MAX_HISTORY = btb_pkg::MAX_HISTORY
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire btb_pkg::in_item_t       in_data,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output btb_pkg::out_item_t           out_data,
  input  wire logic                    cfg_we,
  input  wire logic [2:0]              cfg_index,
  input  wire logic [btb_pkg::CFG_W-1:0] cfg_data
);

  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int HW = MAX_HISTORY;
  localparam int SW = 1 << HW;
  // the clear sweep covers max(rows, shared entries)
  localparam int SWEEP = (MAX_ENTRIES > SW) ? MAX_ENTRIES : SW;
  localparam int CW = $clog2(SWEEP + 1);

  btb_pkg::cfg_t cfg;
  btb_pkg::state_t state, state_next;
  btb_pkg::in_item_t item;

  logic [CW-1:0] sweep;
  logic clearing;
  logic [MAX_ENTRIES-1:0] valid_bits;
  logic [29:0] tag_mem [MAX_ENTRIES];
  logic [31:0] tgt_mem [MAX_ENTRIES];
  logic [HW-1:0] hist_mem [MAX_ENTRIES];
  logic [29:0] tag_rd;
  logic [31:0] tgt_rd;
  logic [HW-1:0] hist_rd;
  logic [1:0] shared [SW];
  logic [1:0] shared_rd;
  logic [1:0] ent_rd;
  logic [HW-1:0] ghist;
  logic last_hit;
  logic [31:0] branches, flushes;
  logic refill;

  // effective configuration
  logic [2:0] elog;
  logic [3:0] ehist;
  logic [4:0] etag;
  logic [HW-1:0] hmask;
  logic [31:0] imask, tmask;

  always_comb begin
    elog = (cfg.entries_log2 > 3'd5) ? 3'd5 : cfg.entries_log2;
    ehist = (cfg.history_bits == 4'd0) ? 4'd1 :
            ((cfg.history_bits > 4'(HW)) ? 4'(HW) : cfg.history_bits);
    etag = (cfg.tag_bits > 5'd30) ? 5'd30 : cfg.tag_bits;
    hmask = HW'((32'd1 << ehist) - 32'd1);
    imask = (32'd1 << elog) - 32'd1;
    tmask = (32'd1 << etag) - 32'd1;
  end

  function automatic logic [IW-1:0] idx_of(input logic [31:0] pc, input logic [31:0] m);
    logic [31:0] v;
    v = (pc >> 2) & m;
    return v[IW-1:0];
  endfunction

  logic [IW-1:0] in_idx, idx;
  logic [29:0] tag;
  assign in_idx = idx_of(in_data.pc, imask);
  assign idx = idx_of(item.pc, imask);
  assign tag = 30'(((item.pc >> (elog + 3'd2)) & tmask));

  // history and counter column, computed in read cycle from input
  logic [HW-1:0] in_hist, col_in;
  logic [HW-1:0] hsel;
  logic [HW-1:0] col;
  logic [HW-1:0] pcx;

  // history is in registers per entry (read at one address), shared table index
  always_comb begin
    in_hist = cfg.use_global_history ? ghist : hist_mem[in_idx];
    if (in_data.operation == btb_pkg::OP_RESOLVE && !last_hit && !cfg.use_global_history)
      in_hist = '0;
    pcx = '0;
    if (cfg.use_global_table) begin
      case (cfg.share_mode)
        2'd1: pcx = in_data.pc[2 +: HW];
        2'd2: pcx = in_data.pc[16 +: HW];
        default: pcx = '0;
      endcase
    end
    col_in = (in_hist ^ pcx) & hmask;
  end

  logic row_fill, cell_wr;
  logic [IW-1:0] wrow;
  logic [1:0] cnt_old, cnt_new;

  btb_counter_mem #(.ENTRIES(MAX_ENTRIES), .HIST(HW)) u_cnt (
    .clk(clk), .rd_row(in_idx), .rd_col(col_in), .rd_data(ent_rd),
    .wr_row_en(row_fill), .wr_row(wrow), .wr_fill(cfg.initial_state),
    .wr_cell_en(cell_wr), .wr_col(col), .wr_data(cnt_new)
  );

  logic exec_res, exec_alloc;
  assign exec_res = (state == btb_pkg::ST_EXEC) && item.operation == btb_pkg::OP_RESOLVE;
  assign exec_alloc = exec_res && !last_hit;
  assign clearing = (state == btb_pkg::ST_CLEAR);
  // allocation refills the entry row together with the trained counter
  assign row_fill = clearing || (exec_alloc && !cfg.use_global_table);
  assign wrow = clearing ? sweep[IW-1:0] : idx;
  // fresh row after allocation reads as initial state
  assign cnt_old = (exec_alloc && !cfg.use_global_table) ? cfg.initial_state :
                   (cfg.use_global_table ? shared_rd : ent_rd);
  assign cnt_new = item.resolved_taken ? ((cnt_old == 2'd3) ? 2'd3 : cnt_old + 2'd1)
                                       : ((cnt_old == 2'd0) ? 2'd0 : cnt_old - 2'd1);
  assign cell_wr = exec_res && !cfg.use_global_table;
  assign hsel = cfg.use_global_history ? ghist : (exec_alloc ? '0 : hist_rd);

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item <= in_data;
      col <= col_in;
      tag_rd <= tag_mem[in_idx];
      tgt_rd <= tgt_mem[in_idx];
      hist_rd <= hist_mem[in_idx];
      shared_rd <= shared[col_in];
    end
    if (clearing) begin
      shared[sweep[HW-1:0]] <= cfg.initial_state;
    end else if (exec_res && cfg.use_global_table) begin
      shared[col] <= cnt_new;
    end
    if (rst) begin
      for (int i = 0; i < MAX_ENTRIES; i++) hist_mem[i] <= '0;
    end else if (exec_res) begin
      tgt_mem[idx] <= item.resolved_target;
      if (!last_hit) tag_mem[idx] <= tag;
      if (!cfg.use_global_history) hist_mem[idx] <= ((hsel << 1) & hmask) | HW'(item.resolved_taken);
    end
  end

  logic hit;
  assign hit = valid_bits[idx] && tag_rd == tag;

  always_comb begin
    state_next = state;
    case (state)
      btb_pkg::ST_CLEAR: if (!refill && sweep == CW'(SWEEP - 1)) state_next = btb_pkg::ST_IDLE;
      btb_pkg::ST_IDLE: if (refill) state_next = btb_pkg::ST_CLEAR;
                        else if (in_valid) state_next = btb_pkg::ST_EXEC;
      btb_pkg::ST_EXEC: state_next = btb_pkg::ST_OUT;
      btb_pkg::ST_OUT: if (!out_stall) state_next = btb_pkg::ST_IDLE;
      default: state_next = btb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state != btb_pkg::ST_IDLE) || refill;
    out_valid = (state == btb_pkg::ST_OUT);
  end

  assign refill = cfg_we && cfg_index == btb_pkg::CFG_INITIAL_STATE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= btb_pkg::ST_CLEAR;
      sweep <= '0;
      valid_bits <= '0;
      ghist <= '0;
      last_hit <= 1'b0;
      branches <= '0;
      flushes <= '0;
      cfg <= '{3'd0, 4'd1, 5'd0, 2'd1, 1'b0, 1'b0, 2'd0};
    end else begin
      state <= state_next;
      sweep <= (clearing && !refill) ? sweep + CW'(1) : '0;
      if (cfg_we) begin
        case (cfg_index)
          btb_pkg::CFG_ENTRIES_LOG2: cfg.entries_log2 <= cfg_data[2:0];
          btb_pkg::CFG_HISTORY_BITS: cfg.history_bits <= cfg_data[3:0];
          btb_pkg::CFG_TAG_BITS: cfg.tag_bits <= cfg_data[4:0];
          btb_pkg::CFG_INITIAL_STATE: cfg.initial_state <= cfg_data[1:0];
          btb_pkg::CFG_USE_GLOBAL_HISTORY: cfg.use_global_history <= cfg_data[0];
          btb_pkg::CFG_USE_GLOBAL_TABLE: cfg.use_global_table <= cfg_data[0];
          btb_pkg::CFG_SHARE_MODE:
            cfg.share_mode <= (cfg_data[1:0] == 2'd3) ? 2'd0 : cfg_data[1:0];
          default: ;
        endcase
      end
      if (state == btb_pkg::ST_EXEC) begin
        out_data.branch_count <= branches;
        out_data.flush_count <= flushes;
        if (item.operation == btb_pkg::OP_PREDICT) begin
          last_hit <= hit;
          out_data.predict_taken <= 1'b0;
          out_data.next_fetch_address <= item.pc + 32'd4;
          if (hit && (cfg.use_global_table ? shared_rd[1] : ent_rd[1])) begin
            out_data.predict_taken <= 1'b1;
            out_data.next_fetch_address <= tgt_rd;
          end
        end else begin
          out_data.predict_taken <= 1'b0;
          out_data.next_fetch_address <= '0;
          branches <= branches + 32'd1;
          out_data.branch_count <= branches + 32'd1;
          if (item.used_prediction != (item.resolved_taken ? item.resolved_target
                                                           : item.pc + 32'd4)) begin
            flushes <= flushes + 32'd1;
            out_data.flush_count <= flushes + 32'd1;
          end
          if (!last_hit) valid_bits[idx] <= 1'b1;
          if (cfg.use_global_history)
            ghist <= ((ghist << 1) & hmask) | HW'(item.resolved_taken);
        end
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(state == btb_pkg::ST_CLEAR))
    else $error("result during clear");
  assert property (@(posedge clk) disable iff (rst)
    (state == btb_pkg::ST_EXEC) |=> out_valid)
    else $error("missing result");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("result dropped");

endmodule
`default_nettype wire
